/* src/dwv_pkg.sv */
// Shared types, constants and codes of the dual wheel velocity controller.
`default_nettype none
package dwv_pkg;

   // Fixed formats: velocities carry 12 fraction bits, counts are 32 bits.
   localparam int VelFracBits = 12;
   localparam int CountWidth = 32;
   localparam int SumShift = 8 + VelFracBits;

   // Speed per summed tick, Q0.24 m/s.
   localparam logic signed [23:0] SPEED_PER_SUM = 24'sd2141229;
   // Reciprocal of 50 at 24 fraction bits, rounded up; exact for the error range.
   localparam logic signed [23:0] RECIP_50 = 24'sd335545;
   localparam logic signed [20:0] INTEGRAL_LIM = 21'sd409600;
   // Deadband threshold compared against |v| times 100.
   localparam logic [22:0] DEADBAND = 23'd4096;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_KV = 3'd0;
   localparam logic [2:0] CSR_KS_LEFT = 3'd1;
   localparam logic [2:0] CSR_KS_RIGHT = 3'd2;
   localparam logic [2:0] CSR_KP = 3'd3;
   localparam logic [2:0] CSR_KI = 3'd4;
   localparam logic [2:0] CSR_KD = 3'd5;
   localparam logic [2:0] CSR_SLEW_LIMIT = 3'd6;
   localparam logic [2:0] CSR_SMOOTH_WEIGHT = 3'd7;

   // Gains shared by both lanes.
   typedef struct packed {
      logic [15:0] kv;
      logic [15:0] kp;
      logic [15:0] ki;
      logic [15:0] kd;
      logic [12:0] slew_limit;
      logic [8:0]  smooth_weight;
   } gains_type;

   // Control from the top level to one lane.
   typedef struct packed {
      logic start;
      logic hold;
   } lane_ctl_type;

   // Status from one lane to the top level.
   typedef struct packed {
      logic done;
   } lane_stat_type;

   // Lane sequencer steps; each multiplying step uses the shared multiplier once.
   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_SPD_MUL,
      STEP_SPD_RND,
      STEP_EMA_NEW,
      STEP_EMA_OLD,
      STEP_INT,
      STEP_KV,
      STEP_KP,
      STEP_KI,
      STEP_KD,
      STEP_OUT
   } step_type;

   // Top level control states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } top_state_type;

endpackage
`default_nettype wire

/* src/dual_wheel_velocity_pid.sv */
// Top level: configuration registers, control sequencer, two lanes, output register.
// A word passes the ten sequencer steps of each lane, then waits in the drain state for
// a free output register; a hold word goes straight to the drain state. A new word is
// accepted only in the idle state, which follows the drain.
// A result waiting at the output does not block acceptance; the next result waits for it.
// Reset is synchronous, active high: it restores defaults and zeros the lane history.
`default_nettype none
module dual_wheel_velocity_pid import dwv_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_hold,
   input  wire logic signed [13:0] req_target_left,
   input  wire logic signed [13:0] req_target_right,
   input  wire logic [31:0]        req_count_front_left,
   input  wire logic [31:0]        req_count_rear_left,
   input  wire logic [31:0]        req_count_front_right,
   input  wire logic [31:0]        req_count_rear_right,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_duty_left,
   output logic                    rsp_reverse_left,
   output logic [7:0]              rsp_duty_right,
   output logic                    rsp_reverse_right,
   output logic signed [15:0]      rsp_speed_left,
   output logic signed [15:0]      rsp_speed_right,
   output logic signed [31:0]      rsp_odo_front_left,
   output logic signed [31:0]      rsp_odo_rear_left,
   output logic signed [31:0]      rsp_odo_front_right,
   output logic signed [31:0]      rsp_odo_rear_right,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   gains_type  gains_ff;
   logic [7:0] ks_left_ff, ks_right_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kv            <= 16'd15360;
         ks_left_ff             <= 8'd115;
         ks_right_ff            <= 8'd125;
         gains_ff.kp            <= 16'd40960;
         gains_ff.ki            <= 16'd23040;
         gains_ff.kd            <= 16'd0;
         gains_ff.slew_limit    <= 13'd123;
         gains_ff.smooth_weight <= 9'd77;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KV:            gains_ff.kv <= csr_wdata;
            CSR_KS_LEFT:       ks_left_ff <= csr_wdata[7:0];
            CSR_KS_RIGHT:      ks_right_ff <= csr_wdata[7:0];
            CSR_KP:            gains_ff.kp <= csr_wdata;
            CSR_KI:            gains_ff.ki <= csr_wdata;
            CSR_KD:            gains_ff.kd <= csr_wdata;
            CSR_SLEW_LIMIT:    gains_ff.slew_limit <= csr_wdata[12:0];
            CSR_SMOOTH_WEIGHT: gains_ff.smooth_weight <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   top_state_type state_ff, state_in;
   logic          accept, out_free, load;
   logic          rsp_valid_ff, rsp_valid_in;
   lane_ctl_type  ctl;
   lane_stat_type stat_l, stat_r;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_hold ? ST_DRAIN : ST_RUN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN:   state_in = stat_l.done ? ST_DRAIN : ST_RUN;
         ST_DRAIN: state_in = out_free ? ST_IDLE : ST_DRAIN;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_stall = state_ff != ST_IDLE;
      ctl.start = state_ff == ST_IDLE && req_valid;
      ctl.hold  = req_hold;
      load      = state_ff == ST_DRAIN && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   logic [7:0]         duty_l, duty_r;
   logic               rev_l, rev_r;
   logic signed [15:0] spd_l, spd_r;
   logic signed [31:0] of_l, or_l, of_r, or_r;

   dwv_lane u_lane_left (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .gains       (gains_ff),
      .ks          (ks_left_ff),
      .target      (req_target_left),
      .count_front (req_count_front_left),
      .count_rear  (req_count_rear_left),
      .stat        (stat_l),
      .duty        (duty_l),
      .rev         (rev_l),
      .speed       (spd_l),
      .odo_front   (of_l),
      .odo_rear    (or_l)
   );

   dwv_lane u_lane_right (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .gains       (gains_ff),
      .ks          (ks_right_ff),
      .target      (req_target_right),
      .count_front (req_count_front_right),
      .count_rear  (req_count_rear_right),
      .stat        (stat_r),
      .duty        (duty_r),
      .rev         (rev_r),
      .speed       (spd_r),
      .odo_front   (of_r),
      .odo_rear    (or_r)
   );

   // Merge stage: both lane results go into one output word.
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_duty_left       <= duty_l;
         rsp_reverse_left    <= rev_l;
         rsp_duty_right      <= duty_r;
         rsp_reverse_right   <= rev_r;
         rsp_speed_left      <= spd_l;
         rsp_speed_right     <= spd_r;
         rsp_odo_front_left  <= of_l;
         rsp_odo_rear_left   <= or_l;
         rsp_odo_front_right <= of_r;
         rsp_odo_rear_right  <= or_r;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // Both lanes run the same sequence and finish together.
   a_lanes_sync: assert property (@(posedge clock) disable iff (reset)
      stat_l.done == stat_r.done)
      else $error("lanes finished out of step");

   // An accepted word always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");

   // A drain with a free output register presents a word next cycle.
   a_drain_load: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("drained word not presented");
`endif

endmodule
`default_nettype wire

/* src/dwv_lane.sv */
// One wheel side: speed estimate, slew limit and PID on a shared multiplier.
`default_nettype none
module dwv_lane import dwv_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lane_ctl_type       ctl,
   input  wire gains_type          gains,
   input  wire logic [7:0]         ks,
   input  wire logic signed [13:0] target,
   input  wire logic [31:0]        count_front,
   input  wire logic [31:0]        count_rear,
   output lane_stat_type           stat,
   output logic [7:0]              duty,
   output logic                    rev,
   output logic signed [15:0]      speed,
   output logic signed [31:0]      odo_front,
   output logic signed [31:0]      odo_rear
);

   step_type step_ff, step_in;

   logic signed [15:0] slew_ff, mv_ff, pm_ff, speed_ff;
   logic signed [19:0] iacc_ff, integ_ff;
   logic [31:0]        last_f_ff, last_r_ff, odo_f_ff, odo_r_ff;
   logic signed [32:0] dsum_ff;
   logic               ndir_ff, tsmall_ff;
   logic signed [57:0] p_ff;
   logic signed [27:0] acc_ff;
   logic signed [16:0] e_ff;
   logic signed [22:0] dpm50_ff;
   logic signed [43:0] sum_ff;
   logic [7:0]         duty_ff;
   logic               rev_ff;

   logic signed [33:0] mul_a;
   logic signed [23:0] mul_b;
   logic signed [57:0] prod;

   // Step sequencing.
   always_comb begin
      case (step_ff)
         STEP_IDLE:    step_in = (ctl.start && !ctl.hold) ? STEP_SPD_MUL : STEP_IDLE;
         STEP_SPD_MUL: step_in = STEP_SPD_RND;
         STEP_SPD_RND: step_in = STEP_EMA_NEW;
         STEP_EMA_NEW: step_in = STEP_EMA_OLD;
         STEP_EMA_OLD: step_in = STEP_INT;
         STEP_INT:     step_in = STEP_KV;
         STEP_KV:      step_in = STEP_KP;
         STEP_KP:      step_in = STEP_KI;
         STEP_KI:      step_in = STEP_KD;
         STEP_KD:      step_in = STEP_OUT;
         default:      step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Effective smoothing weight, capped at one.
   logic [8:0] alpha;
   assign alpha = (gains.smooth_weight > 9'd256) ? 9'd256 : gains.smooth_weight;

   // Magnitude of the error plus half the divisor, for the rounded divide by 50.
   logic [17:0] e_abs_half;
   assign e_abs_half = (e_ff < 0) ? 18'(-e_ff) + 18'd25 : 18'(e_ff) + 18'd25;

   // Operand selection of the shared multiplier.
   always_comb begin
      case (step_ff)
         STEP_SPD_MUL: begin
            mul_a = 34'(dsum_ff);
            mul_b = SPEED_PER_SUM;
         end
         STEP_EMA_NEW: begin
            mul_a = 34'($signed({1'b0, alpha}));
            mul_b = 24'(speed_ff);
         end
         STEP_EMA_OLD: begin
            mul_a = 34'($signed({1'b0, 10'd256 - {1'b0, alpha}}));
            mul_b = 24'(mv_ff);
         end
         STEP_INT: begin
            mul_a = 34'($signed({1'b0, e_abs_half}));
            mul_b = RECIP_50;
         end
         STEP_KV: begin
            mul_a = 34'($signed({1'b0, gains.kv}));
            mul_b = 24'(slew_ff);
         end
         STEP_KP: begin
            mul_a = 34'($signed({1'b0, gains.kp}));
            mul_b = 24'(e_ff);
         end
         STEP_KI: begin
            mul_a = 34'($signed({1'b0, gains.ki}));
            mul_b = 24'(integ_ff);
         end
         STEP_KD: begin
            mul_a = 34'($signed({1'b0, gains.kd}));
            mul_b = 24'(dpm50_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Count deltas and slew limit, taken in the accepting cycle.
   logic signed [31:0] df, dr;
   logic signed [16:0] tdiff, mstep;
   logic signed [15:0] slew_next;
   assign df = $signed(count_front - last_f_ff);
   assign dr = $signed(count_rear - last_r_ff);
   assign tdiff = 17'(target) - 17'(slew_ff);
   assign mstep = $signed({4'd0, gains.slew_limit});
   always_comb begin
      if (tdiff > mstep) begin
         slew_next = slew_ff + 16'($signed({3'd0, gains.slew_limit}));
      end else if (tdiff < -mstep) begin
         slew_next = slew_ff - 16'($signed({3'd0, gains.slew_limit}));
      end else begin
         slew_next = 16'(target);
      end
   end

   // Rounded, saturated speed with the direction of travel applied.
   logic [57:0]        p_abs;
   logic [45:0]        rnd;
   logic signed [15:0] spd_sat, spd_dir;
   assign p_abs = p_ff[57] ? 58'(-p_ff) : 58'(p_ff);
   assign rnd = 46'((p_abs + 58'd2048) >> 12);
   always_comb begin
      if (!p_ff[57]) begin
         spd_sat = (rnd > 46'd32767) ? 16'sh7FFF : 16'(rnd);
      end else begin
         spd_sat = (rnd > 46'd32768) ? 16'sh8000 : 16'(-$signed(17'(rnd)));
      end
      if (!ndir_ff) begin
         spd_dir = spd_sat;
      end else begin
         spd_dir = (spd_sat == 16'sh8000) ? 16'sh7FFF : -spd_sat;
      end
   end

   // Smoothed speed, error and derivative term.
   logic signed [27:0] msum;
   logic signed [15:0] m_new;
   logic signed [16:0] dpm;
   assign msum = acc_ff + prod[27:0];
   assign m_new = msum[23:8];
   assign dpm = 17'(pm_ff) - 17'(m_new);

   // Integral update with clamp.
   logic [16:0]        q;
   logic signed [20:0] rd, isum;
   assign q = prod[40:24];
   assign rd = (e_ff < 0) ? -$signed({4'd0, q}) : $signed({4'd0, q});
   assign isum = 21'(iacc_ff) + rd;

   // Static friction term signed by the slewed velocity.
   logic signed [43:0] ks_term;
   assign ks_term = (slew_ff > 0) ? $signed({16'd0, ks, 20'd0})
                                  : -$signed({16'd0, ks, 20'd0});

   // Deadband tests and output magnitude.
   logic [15:0] s_abs;
   logic [22:0] s_x100;
   logic        moving, halt;
   logic [43:0] sum_abs;
   logic [23:0] mag;
   assign s_abs = (slew_ff < 0) ? 16'(-slew_ff) : 16'(slew_ff);
   assign s_x100 = 23'(s_abs) * 23'd100;
   assign moving = s_x100 > DEADBAND;
   assign halt = (s_x100 < DEADBAND) && tsmall_ff;
   assign sum_abs = sum_ff[43] ? 44'(-sum_ff) : 44'(sum_ff);
   assign mag = moving ? 24'(sum_abs >> SumShift) : 24'd0;

   // Target small enough for the halt deadband.
   logic [13:0] t_abs;
   assign t_abs = (target < 0) ? 14'(-target) : 14'(target);

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slew_ff   <= '0;
         mv_ff     <= '0;
         pm_ff     <= '0;
         iacc_ff   <= '0;
         last_f_ff <= '0;
         last_r_ff <= '0;
         odo_f_ff  <= '0;
         odo_r_ff  <= '0;
         duty_ff   <= '0;
         rev_ff    <= 1'b0;
      end else begin
         if (step_ff == STEP_IDLE && ctl.start) begin
            if (ctl.hold) begin
               slew_ff <= '0;
               duty_ff <= '0;
               rev_ff  <= 1'b0;
            end else begin
               ndir_ff   <= slew_ff < 0;
               slew_ff   <= slew_next;
               tsmall_ff <= (23'(t_abs) * 23'd100) < DEADBAND;
               last_f_ff <= count_front;
               last_r_ff <= count_rear;
               dsum_ff   <= 33'(df) + 33'(dr);
               odo_f_ff  <= (slew_ff < 0) ? odo_f_ff - 32'(df) : odo_f_ff + 32'(df);
               odo_r_ff  <= (slew_ff < 0) ? odo_r_ff - 32'(dr) : odo_r_ff + 32'(dr);
            end
         end
         case (step_ff)
            STEP_SPD_MUL: p_ff <= prod;
            STEP_SPD_RND: speed_ff <= spd_dir;
            STEP_EMA_NEW: acc_ff <= prod[27:0] + 28'sd128;
            STEP_EMA_OLD: begin
               mv_ff    <= m_new;
               pm_ff    <= m_new;
               e_ff     <= 17'(slew_ff) - 17'(m_new);
               dpm50_ff <= 23'(dpm) * 23'sd50;
            end
            STEP_INT: begin
               if (isum > INTEGRAL_LIM) begin
                  integ_ff <= 20'(INTEGRAL_LIM);
               end else if (isum < -INTEGRAL_LIM) begin
                  integ_ff <= 20'(-INTEGRAL_LIM);
               end else begin
                  integ_ff <= 20'(isum);
               end
            end
            STEP_KV: sum_ff <= 44'(prod) + ks_term;
            STEP_KP, STEP_KI, STEP_KD: sum_ff <= sum_ff + 44'(prod);
            STEP_OUT: begin
               rev_ff  <= moving && sum_ff[43] && (mag != 24'd0);
               duty_ff <= (halt || mag == 24'd0) ? 8'd0 :
                          ((mag > 24'd255) ? 8'd255 : 8'(mag));
               iacc_ff <= (!moving || halt) ? 20'sd0 : integ_ff;
            end
            default: ;
         endcase
      end
   end

   assign stat.done = step_ff == STEP_OUT;
   assign duty      = duty_ff;
   assign rev       = rev_ff;
   assign speed     = mv_ff;
   assign odo_front = $signed(odo_f_ff);
   assign odo_rear  = $signed(odo_r_ff);

endmodule
`default_nettype wire

/* dv/dual_wheel_velocity_pid_test.sv */
// Self-checking testbench of the dual wheel velocity controller with a scoreboard class.
`default_nettype none
module dual_wheel_velocity_pid_test;
   import dwv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // One command word as driven on the request channel.
   typedef struct packed {
      logic               hold;
      logic signed [13:0] target_left;
      logic signed [13:0] target_right;
      logic [3:0][31:0]   count;
   } command_word_type;

   // One drive word as seen on the response channel.
   typedef struct packed {
      logic [7:0]       duty_left;
      logic             reverse_left;
      logic [7:0]       duty_right;
      logic             reverse_right;
      logic [15:0]      speed_left;
      logic [15:0]      speed_right;
      logic [3:0][31:0] odo;
   } drive_word_type;

   // Tracks gains and controller state, predicts each drive word and checks it.
   class drive_scoreboard;
      longint kv, ks_left, ks_right, kp, ki, kd, slew_limit, smooth_weight;
      longint slewed[2], measured[2], prev_measured[2], integral[2];
      logic [31:0] last_count[4];
      logic [31:0] odometry[4];
      drive_word_type pending_drive[$];
      int mismatches;

      function new();
         kv = 15360; ks_left = 115; ks_right = 125; kp = 40960;
         ki = 23040; kd = 0; slew_limit = 123; smooth_weight = 77;
         for (int i = 0; i < 2; i++) begin
            slewed[i] = 0; measured[i] = 0; prev_measured[i] = 0; integral[i] = 0;
         end
         for (int i = 0; i < 4; i++) begin
            last_count[i] = 0; odometry[i] = 0;
         end
         mismatches = 0;
      endfunction

      // Registers keep only as many bits as they are wide.
      function void write_gain(logic [2:0] index, logic [15:0] value);
         case (index)
            CSR_KV: kv = longint'(value);
            CSR_KS_LEFT: ks_left = longint'(value[7:0]);
            CSR_KS_RIGHT: ks_right = longint'(value[7:0]);
            CSR_KP: kp = longint'(value);
            CSR_KI: ki = longint'(value);
            CSR_KD: kd = longint'(value);
            CSR_SLEW_LIMIT: slew_limit = longint'(value[12:0]);
            CSR_SMOOTH_WEIGHT: smooth_weight = longint'(value[8:0]);
            default: ;
         endcase
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint magnitude(longint v);
         return v < 0 ? -v : v;
      endfunction

      // Rounds half away from zero while dropping the low bits.
      function longint shift_round(longint v, int bits);
         longint a;
         a = (magnitude(v) + (longint'(1) << (bits - 1))) >> bits;
         return v < 0 ? -a : a;
      endfunction

      function longint wheel_delta(int wheel, logic [31:0] current);
         logic [31:0] d;
         d = current - last_count[wheel];
         last_count[wheel] = current;
         return longint'($signed(d));
      endfunction

      // One side of the controller for one tick.
      function void control_side(int side, longint target, logic [31:0] cf,
                                 logic [31:0] cr, longint ks,
                                 output logic [7:0] duty, output logic reverse);
         longint df, dr, spd, m, s, e, integ, sum, mag, alpha;
         bit neg;
         neg = slewed[side] < 0;
         df = wheel_delta(side * 2, cf);
         dr = wheel_delta(side * 2 + 1, cr);
         spd = clamp(shift_round((df + dr) * 2141229, 12), -32768, 32767);
         if (neg) begin
            spd = clamp(-spd, -32768, 32767);
            df = -df;
            dr = -dr;
         end
         odometry[side * 2] += 32'(df);
         odometry[side * 2 + 1] += 32'(dr);

         alpha = smooth_weight > 256 ? 256 : smooth_weight;
         m = (alpha * spd + (256 - alpha) * measured[side] + 128) >>> 8;
         measured[side] = m;

         // Slew the setpoint toward the target.
         s = slewed[side];
         if (target - s > slew_limit) s += slew_limit;
         else if (target - s < -slew_limit) s -= slew_limit;
         else s = target;
         slewed[side] = s;

         e = s - m;
         integ = (magnitude(e) + 25) / 50;
         integ = clamp(integral[side] + (e < 0 ? -integ : integ), -409600, 409600);

         // The moving deadband removes the whole drive sum.
         sum = 0;
         if (magnitude(s) * 100 > 4096) begin
            sum = kv * s + (s > 0 ? 1 : -1) * (ks << 20) + kp * e + ki * integ
                  + kd * (prev_measured[side] - m) * 50;
         end else begin
            integ = 0;
         end
         prev_measured[side] = m;

         mag = magnitude(sum) >> 20;
         reverse = sum < 0 && mag != 0;
         if (mag > 255) mag = 255;
         // Halt deadband: stopped and told to stay stopped.
         if (magnitude(s) * 100 < 4096 && magnitude(target) * 100 < 4096) begin
            mag = 0;
            integ = 0;
         end
         integral[side] = integ;
         duty = mag[7:0];
      endfunction

      // An accepted command word yields exactly one drive word.
      function void note_command(command_word_type c);
         drive_word_type d;
         d = '0;
         if (c.hold) begin
            slewed[0] = 0;
            slewed[1] = 0;
         end else begin
            control_side(0, c.target_left, c.count[0], c.count[1], ks_left,
                         d.duty_left, d.reverse_left);
            control_side(1, c.target_right, c.count[2], c.count[3], ks_right,
                         d.duty_right, d.reverse_right);
         end
         d.speed_left = measured[0][15:0];
         d.speed_right = measured[1][15:0];
         for (int i = 0; i < 4; i++) d.odo[i] = odometry[i];
         pending_drive.push_back(d);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         mismatches++;
         $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
      endtask

      task check_drive(drive_word_type got);
         drive_word_type want;
         if (pending_drive.size() == 0) begin
            report_mismatch("unexpected drive word", 1, 0);
            return;
         end
         want = pending_drive.pop_front();
         if (got.duty_left !== want.duty_left)
            report_mismatch("duty_left", got.duty_left, want.duty_left);
         if (got.reverse_left !== want.reverse_left)
            report_mismatch("reverse_left", got.reverse_left, want.reverse_left);
         if (got.duty_right !== want.duty_right)
            report_mismatch("duty_right", got.duty_right, want.duty_right);
         if (got.reverse_right !== want.reverse_right)
            report_mismatch("reverse_right", got.reverse_right, want.reverse_right);
         if (got.speed_left !== want.speed_left)
            report_mismatch("speed_left", $signed(got.speed_left), $signed(want.speed_left));
         if (got.speed_right !== want.speed_right)
            report_mismatch("speed_right", $signed(got.speed_right),
                            $signed(want.speed_right));
         for (int i = 0; i < 4; i++)
            if (got.odo[i] !== want.odo[i])
               report_mismatch($sformatf("odo[%0d]", i), $signed(got.odo[i]),
                               $signed(want.odo[i]));
      endtask
   endclass

   bit clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_hold = 0;
   logic signed [13:0] req_target_left = 0, req_target_right = 0;
   logic [31:0] req_count_front_left = 0, req_count_rear_left = 0;
   logic [31:0] req_count_front_right = 0, req_count_rear_right = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [7:0] rsp_duty_left, rsp_duty_right;
   logic rsp_reverse_left, rsp_reverse_right;
   logic signed [15:0] rsp_speed_left, rsp_speed_right;
   logic signed [31:0] rsp_odo_front_left, rsp_odo_rear_left;
   logic signed [31:0] rsp_odo_front_right, rsp_odo_rear_right;
   logic csr_we = 0;
   logic [2:0] csr_index = CSR_KV;
   logic [15:0] csr_wdata = 0;

   drive_scoreboard board = new();
   logic [31:0] wheel_count[4] = '{default: 0};
   logic signed [13:0] last_target[2] = '{default: 0};
   bit steady = 0;
   bit long_hold = 0;

   always #1 clock = ~clock;

   dual_wheel_velocity_pid u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_hold, .req_target_left,
      .req_target_right, .req_count_front_left, .req_count_rear_left,
      .req_count_front_right, .req_count_rear_right, .rsp_valid, .rsp_stall,
      .rsp_duty_left, .rsp_reverse_left, .rsp_duty_right, .rsp_reverse_right,
      .rsp_speed_left, .rsp_speed_right, .rsp_odo_front_left, .rsp_odo_rear_left,
      .rsp_odo_front_right, .rsp_odo_rear_right, .csr_we, .csr_index, .csr_wdata
   );

   // Check every drive word taken off the response channel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_drive({rsp_duty_left, rsp_reverse_left, rsp_duty_right,
                            rsp_reverse_right, rsp_speed_left, rsp_speed_right,
                            rsp_odo_rear_right, rsp_odo_front_right,
                            rsp_odo_rear_left, rsp_odo_front_left});
   end

   // Receiver: stall for a random spell before each drive word unless steady; once, a long hold.
   initial begin
      int wait_cycles;
      forever begin
         wait_cycles = steady ? 0 : $urandom_range(0, 3);
         if (long_hold) begin
            wait_cycles = 300;
            long_hold = 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task send_command(command_word_type c);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_hold <= c.hold;
      req_target_left <= c.target_left;
      req_target_right <= c.target_right;
      req_count_front_left <= c.count[0];
      req_count_rear_left <= c.count[1];
      req_count_front_right <= c.count[2];
      req_count_rear_right <= c.count[3];
      do @(posedge clock); while (req_stall);
      board.note_command(c);
   endtask

   // Moves each wheel count by the given deltas and sends the tick.
   task send_tick(logic hold, int target_l, int target_r, int d0, int d1, int d2, int d3);
      command_word_type c;
      wheel_count[0] += d0;
      wheel_count[1] += d1;
      wheel_count[2] += d2;
      wheel_count[3] += d3;
      c.hold = hold;
      c.target_left = 14'(target_l);
      c.target_right = 14'(target_r);
      for (int i = 0; i < 4; i++) c.count[i] = wheel_count[i];
      send_command(c);
   endtask

   task write_gain(logic [2:0] index, logic [15:0] value);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      board.write_gain(index, value);
   endtask

   // Let every outstanding drive word come back before touching the gains.
   task drain;
      req_valid <= 0;
      while (board.pending_drive.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function int pick_target(int side);
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return last_target[side];
      if (r < 40) return $urandom_range(0, 100) - 50;
      if (r < 45) return $urandom_range(0, 16383) - 8192;
      return $urandom_range(0, 8192) - 4096;
   endfunction

   // Mostly small encoder motion, with a few wide jumps and raw noise.
   function int pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 80) - 40;
      if (r < 95) return $urandom_range(0, 4000) - 2000;
      return $urandom;
   endfunction

   task random_phase(int words);
      int tl, tr;
      for (int n = 0; n < words; n++) begin
         if (n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
         tl = pick_target(0);
         tr = pick_target(1);
         last_target[0] = 14'(tl);
         last_target[1] = 14'(tr);
         if ($urandom_range(0, 99) < 3) begin
            for (int i = 0; i < 4; i++) wheel_count[i] = $urandom;
         end
         send_tick($urandom_range(0, 99) < 8, tl, tr, pick_delta(), pick_delta(),
                   pick_delta(), pick_delta());
      end
      steady = 0;
   endtask

   initial begin
      logic [15:0] alpha_value;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed ticks under the reset gains.
      send_tick(0, 4096, -4096, 10, 12, -8, -9);
      send_tick(0, 4096, -4096, 30, 28, -25, -27);
      send_tick(0, 4096, -4096, 40, 41, -40, -38);
      send_tick(1, 4096, -4096, 40, 40, 40, 40);
      send_tick(0, 8191, -8192, 0, 0, 0, 0);
      send_tick(0, -4096, 4096, 5, 5, 5, 5);
      send_tick(0, -4096, 4096, -20, -22, 20, 19);
      send_tick(0, -4096, 4096, -30, -30, 30, 30);
      send_tick(0, 40, -40, 0, 0, 0, 0);
      send_tick(0, 41, -41, 0, 0, 0, 0);
      send_tick(0, 0, 0, 0, 0, 0, 0);
      send_tick(0, 0, 0, 0, 0, 0, 0);
      send_tick(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, -32'sh7FFFFFFF, 32'h80000000);
      send_tick(0, 1000, -1000, 32'h80000000, 1, 32'h7FFFFFFF, -1);
      send_tick(1, 0, 0, 0, 0, 0, 0);
      send_tick(0, -8192, 8191, 3, -3, 3, -3);
      send_tick(0, 2, -2, 0, 0, 0, 0);
      for (int i = 0; i < 4; i++) wheel_count[i] = 32'hFFFF_FFFF;
      send_tick(0, 300, -300, 2, 2, -2, -2);
      send_tick(0, 300, -300, 2, 2, -2, -2);
      drain();

      // Phases under different gain sets, the extremes first.
      for (int p = 0; p < 6; p++) begin
         if (p == 0) begin
            write_gain(CSR_KV, 16'd0); write_gain(CSR_KS_LEFT, 16'd0);
            write_gain(CSR_KS_RIGHT, 16'd0); write_gain(CSR_KP, 16'd0);
            write_gain(CSR_KI, 16'd0); write_gain(CSR_KD, 16'd0);
            write_gain(CSR_SLEW_LIMIT, 16'd0); write_gain(CSR_SMOOTH_WEIGHT, 16'd0);
         end else if (p == 1) begin
            write_gain(CSR_KV, 16'hFFFF); write_gain(CSR_KS_LEFT, 16'hFFFF);
            write_gain(CSR_KS_RIGHT, 16'hFFFF); write_gain(CSR_KP, 16'hFFFF);
            write_gain(CSR_KI, 16'hFFFF); write_gain(CSR_KD, 16'hFFFF);
            write_gain(CSR_SLEW_LIMIT, 16'hFFFF); write_gain(CSR_SMOOTH_WEIGHT, 16'hFFFF);
         end else begin
            alpha_value = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 256))
                                                       : 16'($urandom);
            write_gain(CSR_KV, 16'($urandom)); write_gain(CSR_KS_LEFT, 16'($urandom));
            write_gain(CSR_KS_RIGHT, 16'($urandom)); write_gain(CSR_KP, 16'($urandom));
            write_gain(CSR_KI, 16'($urandom));
            write_gain(CSR_KD, 16'($urandom_range(0, 2000)));
            write_gain(CSR_SLEW_LIMIT, $urandom_range(0, 1) == 0 ?
                       16'($urandom_range(0, 4096)) : 16'($urandom));
            write_gain(CSR_SMOOTH_WEIGHT, alpha_value);
         end
         // The receiver holds off once long enough to back up the block.
         if (p == 3) long_hold = 1;
         random_phase(p == 0 ? 150 : 235);
         drain();
      end

      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop if the handshakes never complete.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
